// File: rtl/core/ising_metropolis_sweep_assert.svh
// Assertion macros for the Ising Metropolis sweep block.
`ifndef ISING_METROPOLIS_SWEEP_ASSERT_SVH
`define ISING_METROPOLIS_SWEEP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IMS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IMS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/ims_pkg.sv
// Shared constants, types and codes for the Ising Metropolis sweep block.
package ims_pkg;

   localparam int SIDE      = 64;
   localparam int ROW_W     = (SIDE > 1) ? $clog2(SIDE) : 1;
   localparam int THR_W     = 32;
   localparam int ACC_W     = 13;
   localparam int EN_W      = 15;
   localparam int MAG_W     = 14;
   localparam int ACT_W     = 2;
   localparam int CSR_IDX_W = 1;

   typedef logic [ROW_W-1:0]        row_type;
   typedef logic [SIDE-1:0]         lattice_row_type;
   typedef logic [THR_W-1:0]        threshold_type;
   typedef logic [ACC_W-1:0]        accept_type;
   typedef logic signed [EN_W-1:0]  energy_type;
   typedef logic signed [MAG_W-1:0] magnet_type;
   typedef logic [ACT_W-1:0]        action_code_type;
   typedef logic [CSR_IDX_W-1:0]    csr_index_type;

   localparam row_type ROW_ZERO = row_type'(0);
   localparam row_type ROW_ONE  = row_type'(1);
   localparam row_type ROW_LAST = row_type'(SIDE - 1);

   localparam action_code_type ACT_LOAD    = action_code_type'(0);
   localparam action_code_type ACT_UPDATE  = action_code_type'(1);
   localparam action_code_type ACT_MEASURE = action_code_type'(2);

   localparam csr_index_type CSR_THR_DE4 = csr_index_type'(0);
   localparam csr_index_type CSR_THR_DE8 = csr_index_type'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DOWN,
      ST_EXEC
   } state_type;

endpackage

// File: rtl/core/ims_if.sv
// Valid/ready channel interfaces for the request and response sides.
interface ims_req_if;
   logic                     valid;
   logic                     ready;
   ims_pkg::action_code_type action;
   logic                     spin_in;
   ims_pkg::threshold_type   random_value;

   modport source (output valid, output action, output spin_in, output random_value,
                   input ready);
   modport sink   (input valid, input action, input spin_in, input random_value,
                   output ready);
endinterface

interface ims_rsp_if;
   logic                valid;
   logic                ready;
   logic                spin_out;
   logic                flipped;
   ims_pkg::accept_type accept_count;
   ims_pkg::energy_type energy_sum;
   ims_pkg::magnet_type magnet_sum;
   logic                last_site;

   modport source (output valid, output spin_out, output flipped, output accept_count,
                   output energy_sum, output magnet_sum, output last_site, input ready);
   modport sink   (input valid, input spin_out, input flipped, input accept_count,
                   input energy_sum, input magnet_sum, input last_site, output ready);
endinterface

// File: rtl/core/ising_metropolis_sweep.sv
// Top level of the Ising Metropolis sweep block with its row-wide lattice memory.
//
//   channel   direction  handshake      contents
//   req_ch    in         valid/ready    action, spin_in, random_value
//   rsp_ch    out        valid/ready    spin_out, flipped, sums, last_site
//   csr_*     in         write enable   index 0 de4 threshold, index 1 de8 threshold
//
// Each transaction passes through ST_IDLE, ST_DOWN and ST_EXEC: the lattice memory holds one row per word
// and has two read ports, so the current and upper rows are read first, the lower row next, and the
// updated row is written back in ST_EXEC.
// Reset is synchronous; it clears the position, totals, thresholds and control state
// but not the lattice, which is undefined until loaded.
// A waiting response only stalls the block in ST_EXEC.
`include "ising_metropolis_sweep_assert.svh"

module ising_metropolis_sweep (
   input  logic                           clock,
   input  logic                           reset,
   ims_req_if.sink                        req_ch,
   ims_rsp_if.source                      rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [ims_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ims_pkg::THR_W-1:0]      csr_wr_data
);

   ims_pkg::state_type state_ff, state_in;

   ims_pkg::row_type row_ff, row_in, col_ff, col_in;
   ims_pkg::threshold_type thr4_ff, thr8_ff;
   ims_pkg::accept_type acc_ff, acc_in;
   ims_pkg::energy_type energy_ff, energy_in;
   ims_pkg::magnet_type magnet_ff, magnet_in;

   ims_pkg::action_code_type action_ff;
   logic                     spin_in_ff;
   ims_pkg::threshold_type   random_ff;

   ims_pkg::lattice_row_type lattice_mem [ims_pkg::SIDE];
   ims_pkg::lattice_row_type mem_a_ff, mem_b_ff, cur_row_ff, new_row;

   logic                     rd_a_en, rd_b_en, wr_en, exec_go;
   ims_pkg::row_type         rd_a_addr, rd_b_addr;
   ims_pkg::row_type         row_up, row_down, col_left, col_right;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_spin_ff, rsp_flipped_ff, rsp_last_ff;
   ims_pkg::accept_type      rsp_acc_ff;
   ims_pkg::energy_type      rsp_energy_ff;
   ims_pkg::magnet_type      rsp_magnet_ff;

   logic                     spin_cur, nb_right, nb_left, nb_up, nb_down;
   logic [2:0]               aligned;
   logic [1:0]               bond_aligned;
   logic                     flip_ok, flip, new_spin, last;
   ims_pkg::accept_type      acc_base;
   ims_pkg::energy_type      energy_base;
   ims_pkg::magnet_type      magnet_base;

   assign row_up    = (row_ff == ims_pkg::ROW_ZERO) ? ims_pkg::ROW_LAST : row_ff - ims_pkg::ROW_ONE;
   assign row_down  = (row_ff == ims_pkg::ROW_LAST) ? ims_pkg::ROW_ZERO : row_ff + ims_pkg::ROW_ONE;
   assign col_left  = (col_ff == ims_pkg::ROW_ZERO) ? ims_pkg::ROW_LAST : col_ff - ims_pkg::ROW_ONE;
   assign col_right = (col_ff == ims_pkg::ROW_LAST) ? ims_pkg::ROW_ZERO : col_ff + ims_pkg::ROW_ONE;
   assign last      = (row_ff == ims_pkg::ROW_LAST) && (col_ff == ims_pkg::ROW_LAST);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ims_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ims_pkg::ST_DOWN;
            end
         end
         ims_pkg::ST_DOWN: begin
            state_in = ims_pkg::ST_EXEC;
         end
         ims_pkg::ST_EXEC: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = ims_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ims_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ch.ready = 1'b0;
      rd_a_en      = 1'b0;
      rd_b_en      = 1'b0;
      rd_a_addr    = row_ff;
      rd_b_addr    = row_up;
      exec_go      = 1'b0;
      unique case (state_ff)
         ims_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            rd_a_en      = req_ch.valid;
            rd_b_en      = req_ch.valid;
         end
         ims_pkg::ST_DOWN: begin
            rd_a_en   = 1'b1;
            rd_a_addr = row_down;
         end
         ims_pkg::ST_EXEC: begin
            exec_go = !rsp_valid_ff || rsp_ch.ready;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      spin_cur     = cur_row_ff[col_ff];
      nb_right     = cur_row_ff[col_right];
      nb_left      = cur_row_ff[col_left];
      nb_up        = mem_b_ff[col_ff];
      nb_down      = mem_a_ff[col_ff];
      aligned      = {2'b00, nb_right ~^ spin_cur} + {2'b00, nb_left ~^ spin_cur}
                   + {2'b00, nb_up ~^ spin_cur} + {2'b00, nb_down ~^ spin_cur};
      bond_aligned = {1'b0, nb_right ~^ spin_cur} + {1'b0, nb_down ~^ spin_cur};

      case (aligned) inside
         [3'd0:3'd2]: flip_ok = 1'b1;
         3'd3:        flip_ok = thr4_ff > random_ff;
         default:     flip_ok = thr8_ff > random_ff;
      endcase

      if (row_ff == ims_pkg::ROW_ZERO && col_ff == ims_pkg::ROW_ZERO) begin
         acc_base    = '0;
         energy_base = '0;
         magnet_base = '0;
      end else begin
         acc_base    = acc_ff;
         energy_base = energy_ff;
         magnet_base = magnet_ff;
      end

      flip      = 1'b0;
      new_spin  = spin_cur;
      wr_en     = 1'b0;
      acc_in    = acc_base;
      energy_in = energy_base;
      magnet_in = magnet_base;
      case (action_ff)
         ims_pkg::ACT_LOAD: begin
            new_spin = spin_in_ff;
            wr_en    = exec_go;
         end
         ims_pkg::ACT_UPDATE: begin
            flip     = flip_ok;
            new_spin = spin_cur ^ flip_ok;
            wr_en    = exec_go;
            if (flip_ok) begin
               acc_in = acc_base + ims_pkg::accept_type'(1);
            end
         end
         ims_pkg::ACT_MEASURE: begin
            case (bond_aligned)
               2'd2:    energy_in = energy_base + ims_pkg::energy_type'(2);
               2'd0:    energy_in = energy_base - ims_pkg::energy_type'(2);
               default: energy_in = energy_base;
            endcase
            magnet_in = spin_cur ? magnet_base + ims_pkg::magnet_type'(1)
                                 : magnet_base - ims_pkg::magnet_type'(1);
         end
         default: begin
         end
      endcase

      new_row         = cur_row_ff;
      new_row[col_ff] = new_spin;

      if (last) begin
         row_in = ims_pkg::ROW_ZERO;
         col_in = ims_pkg::ROW_ZERO;
      end else if (col_ff == ims_pkg::ROW_LAST) begin
         row_in = row_ff + ims_pkg::ROW_ONE;
         col_in = ims_pkg::ROW_ZERO;
      end else begin
         row_in = row_ff;
         col_in = col_ff + ims_pkg::ROW_ONE;
      end

      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lattice_mem[row_ff] <= new_row;
      end
      if (rd_a_en) begin
         mem_a_ff <= lattice_mem[rd_a_addr];
      end
      if (rd_b_en) begin
         mem_b_ff <= lattice_mem[rd_b_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ims_pkg::ST_IDLE;
         row_ff       <= ims_pkg::ROW_ZERO;
         col_ff       <= ims_pkg::ROW_ZERO;
         acc_ff       <= '0;
         energy_ff    <= '0;
         magnet_ff    <= '0;
         thr4_ff      <= '0;
         thr8_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_go) begin
            row_ff    <= row_in;
            col_ff    <= col_in;
            acc_ff    <= acc_in;
            energy_ff <= energy_in;
            magnet_ff <= magnet_in;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               ims_pkg::CSR_THR_DE4: thr4_ff <= csr_wr_data;
               ims_pkg::CSR_THR_DE8: thr8_ff <= csr_wr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         action_ff  <= req_ch.action;
         spin_in_ff <= req_ch.spin_in;
         random_ff  <= req_ch.random_value;
      end
      if (state_ff == ims_pkg::ST_DOWN) begin
         cur_row_ff <= mem_a_ff;
      end
      if (exec_go) begin
         rsp_spin_ff    <= new_spin;
         rsp_flipped_ff <= flip;
         rsp_acc_ff     <= acc_in;
         rsp_energy_ff  <= energy_in;
         rsp_magnet_ff  <= magnet_in;
         rsp_last_ff    <= last;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.spin_out     = rsp_spin_ff;
   assign rsp_ch.flipped      = rsp_flipped_ff;
   assign rsp_ch.accept_count = rsp_acc_ff;
   assign rsp_ch.energy_sum   = rsp_energy_ff;
   assign rsp_ch.magnet_sum   = rsp_magnet_ff;
   assign rsp_ch.last_site    = rsp_last_ff;

   `IMS_ASSERT_NEXT(a_accept_to_down, clock, reset, req_ch.valid && req_ch.ready, state_ff == ims_pkg::ST_DOWN, "Accepted transaction did not start the lower row read.")
   `IMS_ASSERT_NEXT(a_flip_only_update, clock, reset, exec_go && action_ff != ims_pkg::ACT_UPDATE, !rsp_ch.flipped, "Flip reported for a non-update transaction.")
   `IMS_ASSERT_NEXT(a_wrap_after_last, clock, reset, exec_go && last, row_ff == ims_pkg::ROW_ZERO && col_ff == ims_pkg::ROW_ZERO, "Position did not wrap after the last site.")
   `IMS_ASSERT_SAME(a_flip_counted, clock, reset, rsp_ch.valid && rsp_ch.flipped, rsp_ch.accept_count != '0, "Flip reported with a zero accept count.")

endmodule
